>>> sv/reader_writer_lock_fifo_macros.svh
// ----------------------------------------------------------------------------
// reader_writer_lock_fifo assertion macros
// shared property forms for the lock manager checks
// ----------------------------------------------------------------------------
`ifndef READER_WRITER_LOCK_FIFO_MACROS_SVH
`define READER_WRITER_LOCK_FIFO_MACROS_SVH

// same-cycle implication
`define RWL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rwl check failed");

// next-cycle implication
`define RWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rwl check failed");

`endif

>>> sv/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// types and constants of the reader-writer lock manager
// ----------------------------------------------------------------------------
package rwl_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int COUNT_WIDTH = 8;
    localparam int MAX_RESULTS = 16;

    localparam int FIELD_ID_W = 8;
    localparam int PTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int NRES_W     = $clog2(MAX_RESULTS + 1);
    localparam int ID_KEEP    = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;

    localparam logic [FIELD_ID_W-1:0]  ID_MASK   = FIELD_ID_W'((64'd1 << ID_KEEP) - 64'd1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic MODE_READ   = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef logic [FIELD_ID_W-1:0] t_id;

    typedef enum logic [2:0] {
        KIND_GRANT_NOW,
        KIND_QUEUED,
        KIND_GRANT_QUEUED,
        KIND_RELEASED,
        KIND_QUEUE_FULL,
        KIND_COUNT_FULL,
        KIND_RELEASE_IDLE
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_CHECK
    } t_state;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef struct packed {
        t_cnt_op op;
        logic    mode;
    } t_cnt_cmd;

    typedef struct packed {
        logic zero;
        logic full;
        logic mode;
    } t_cnt_stat;

    typedef struct packed {
        logic mode;
        t_id  id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic  valid;
        t_kind kind;
        t_id   id;
        logic  mode;
        logic  last;
    } t_result;

endpackage

>>> sv/rwl_ram.sv
// ----------------------------------------------------------------------------
// rwl_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/rwl_hold.sv
// ----------------------------------------------------------------------------
// rwl_hold
// holder count and held mode with the shared increment/decrement unit
// ----------------------------------------------------------------------------
module rwl_hold
    import rwl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cnt_cmd  i_cmd,
    output t_cnt_stat o_stat
);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   r_mode;
    logic                   n_mode;

    always_comb begin
        n_count = r_count;
        n_mode  = r_mode;
        case (i_cmd.op)
            CNT_INC: begin
                n_count = r_count + COUNT_WIDTH'(1);
                n_mode  = i_cmd.mode;
            end
            CNT_DEC: begin
                n_count = r_count - COUNT_WIDTH'(1);
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_mode  <= MODE_READ;
        end else begin
            r_count <= n_count;
            r_mode  <= n_mode;
        end
    end

    assign o_stat.zero = (r_count == '0);
    assign o_stat.full = (r_count == COUNT_MAX);
    assign o_stat.mode = r_mode;

endmodule

>>> sv/rwl_seq.sv
// ----------------------------------------------------------------------------
// rwl_seq
// request sequencer: decides grants, runs the wait queue and the grant loop
// ----------------------------------------------------------------------------
`include "reader_writer_lock_fifo_macros.svh"

module rwl_seq
    import rwl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_req_type,
    input  logic               i_access_mode,
    input  t_id                i_requester_id,
    output logic               o_busy,
    input  t_cnt_stat          i_cnt_stat,
    output t_cnt_cmd           o_cnt_cmd,
    output logic               o_ram_we,
    output logic [PTR_W-1:0]   o_ram_waddr,
    output logic [ENTRY_W-1:0] o_ram_wdata,
    output logic [PTR_W-1:0]   o_ram_raddr,
    input  logic [ENTRY_W-1:0] i_ram_rdata,
    output t_result            o_res
);

    t_state             r_state;
    t_state             n_state;
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   r_tail;
    logic [PTR_W-1:0]   n_tail;
    logic [QCNT_W-1:0]  r_qcount;
    logic [QCNT_W-1:0]  n_qcount;
    logic [NRES_W-1:0]  r_nres;
    logic [NRES_W-1:0]  n_nres;
    t_result            r_pend;
    t_result            n_pend;
    logic               r_req_type;
    logic               r_req_mode;
    t_id                r_req_id;
    t_entry             entry;
    t_result            fin_res;
    logic               go_on;
    logic               blocked;
    logic               accept;

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign accept  = i_start && (r_state == S_IDLE);
    assign o_busy  = (r_state != S_IDLE);
    assign entry   = t_entry'(i_ram_rdata);
    assign go_on   = (r_qcount != '0) && (r_nres < NRES_W'(MAX_RESULTS)) && !i_cnt_stat.full;
    assign blocked = !i_cnt_stat.zero &&
                     !((i_cnt_stat.mode == MODE_READ) && (entry.mode == MODE_READ));

    always_comb begin
        if (r_pend.valid) begin
            fin_res      = r_pend;
            fin_res.last = 1'b1;
        end else begin
            fin_res = '{valid: 1'b1, kind: KIND_RELEASED, id: r_req_id,
                        mode: r_req_mode, last: 1'b1};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if ((r_req_type == REQ_RELEASE) && !i_cnt_stat.zero) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = go_on ? S_CHECK : S_IDLE;
            end
            S_CHECK: begin
                n_state = blocked ? S_IDLE : S_READ;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_qcount    = r_qcount;
        n_nres      = r_nres;
        n_pend      = r_pend;
        o_cnt_cmd   = '{op: CNT_HOLD, mode: r_req_mode};
        o_ram_we    = 1'b0;
        o_ram_waddr = r_tail;
        o_ram_wdata = {r_req_mode, r_req_id};
        o_res       = '{valid: 1'b0, kind: KIND_RELEASED, id: r_req_id,
                        mode: r_req_mode, last: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_pend.valid = 1'b0;
                    n_nres       = '0;
                end
            end
            S_DECIDE: begin
                o_res.valid = 1'b1;
                o_res.last  = 1'b1;
                if (r_req_type != REQ_RELEASE) begin
                    if (i_cnt_stat.zero) begin
                        o_cnt_cmd.op = CNT_INC;
                        o_res.kind   = KIND_GRANT_NOW;
                    end else if ((r_req_mode == MODE_READ) && (i_cnt_stat.mode == MODE_READ)) begin
                        if (i_cnt_stat.full) begin
                            o_res.kind = KIND_COUNT_FULL;
                        end else begin
                            o_cnt_cmd.op = CNT_INC;
                            o_res.kind   = KIND_GRANT_NOW;
                        end
                    end else if (r_qcount == QCNT_W'(QUEUE_DEPTH)) begin
                        o_res.kind = KIND_QUEUE_FULL;
                    end else begin
                        o_ram_we   = 1'b1;
                        n_tail     = next_pos(r_tail);
                        n_qcount   = r_qcount + QCNT_W'(1);
                        o_res.kind = KIND_QUEUED;
                    end
                end else if (i_cnt_stat.zero) begin
                    o_res.kind = KIND_RELEASE_IDLE;
                end else begin
                    o_cnt_cmd.op = CNT_DEC;
                    o_res.valid  = 1'b0;
                    o_res.last   = 1'b0;
                end
            end
            S_READ: begin
                if (!go_on) begin
                    o_res = fin_res;
                end
            end
            S_CHECK: begin
                if (blocked) begin
                    o_res = fin_res;
                end else begin
                    n_head         = next_pos(r_head);
                    n_qcount       = r_qcount - QCNT_W'(1);
                    n_nres         = r_nres + NRES_W'(1);
                    o_cnt_cmd.op   = CNT_INC;
                    o_cnt_cmd.mode = entry.mode;
                    if (r_pend.valid) begin
                        o_res      = r_pend;
                        o_res.last = 1'b0;
                    end
                    n_pend = '{valid: 1'b1, kind: KIND_GRANT_QUEUED, id: entry.id,
                               mode: entry.mode, last: 1'b0};
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    assign o_ram_raddr = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_qcount <= '0;
            r_nres   <= '0;
            r_pend   <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_qcount <= n_qcount;
            r_nres   <= n_nres;
            r_pend   <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
            r_req_mode <= i_access_mode;
            r_req_id   <= i_requester_id & ID_MASK;
        end
    end

    `RWL_ASSERT_NEXT(a_accept_busy, accept, o_busy)
    `RWL_ASSERT_NEXT(a_last_frees, o_res.valid && o_res.last, !o_busy)
    `RWL_ASSERT_NOW(a_qcount_range, 1'b1, r_qcount <= QCNT_W'(QUEUE_DEPTH))
    `RWL_ASSERT_NOW(a_pop_nonempty, (r_state == S_CHECK) && !blocked, r_qcount != '0)

endmodule

>>> sv/reader_writer_lock_fifo.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_fifo
// reader-writer lock manager for one shared object with a fifo wait queue
// ----------------------------------------------------------------------------
// acquire: busy the cycle after the request; result registered from the decide state
// release: when idle, busy in the decide state only; else decide, then a read and a check
//   state per queued grant (registered queue ram read at the head, then the check)
// at most one result per cycle as single-cycle strobes; the receiver cannot stall
// reset (synchronous, active low) empties the queue and clears the holder count
// ----------------------------------------------------------------------------
module reader_writer_lock_fifo
    import rwl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_req_type,
    input  logic       i_access_mode,
    input  logic [7:0] i_requester_id,
    output logic       o_valid,
    output logic [2:0] o_kind,
    output logic [7:0] o_grant_id,
    output logic       o_grant_mode,
    output logic       o_last
);

    t_cnt_cmd           cnt_cmd;
    t_cnt_stat          cnt_stat;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [PTR_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_result            res;
    logic               r_valid;
    t_result            r_out;

    rwl_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_req_type     (i_req_type),
        .i_access_mode  (i_access_mode),
        .i_requester_id (i_requester_id),
        .o_busy         (busy),
        .i_cnt_stat     (cnt_stat),
        .o_cnt_cmd      (cnt_cmd),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_raddr    (ram_raddr),
        .i_ram_rdata    (ram_rdata),
        .o_res          (res)
    );

    rwl_hold u_hold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cnt_cmd),
        .o_stat  (cnt_stat)
    );

    rwl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= res;
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_out.kind;
    assign o_grant_id   = r_out.id;
    assign o_grant_mode = r_out.mode;
    assign o_last       = r_out.last;

endmodule
